[hw/rtl/afs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types, codes and reset values for the fade-out stop controller.
// ----------------------------------------------------------------------------
package afs_pkg;

   // Gain ramp fraction bits (default) and channel limit
   localparam int GAIN_FRACTION_BITS_DEF = 14;
   localparam int MAX_CHANNELS           = 2;

   // Offset-binary zero level
   localparam logic [7:0] U8_BIAS = 8'h80;

   // Operation codes
   localparam logic [2:0] OP_FRAME = 3'd0;
   localparam logic [2:0] OP_STOP  = 3'd1;
   localparam logic [2:0] OP_PAUSE = 3'd2;
   localparam logic [2:0] OP_ACK   = 3'd3;
   localparam logic [2:0] OP_START = 3'd4;

   // Sample formats
   localparam logic [1:0] FMT_S16 = 2'd0;
   localparam logic [1:0] FMT_S8  = 2'd1;
   localparam logic [1:0] FMT_U8  = 2'd2;
   localparam logic [1:0] FMT_RAW = 2'd3;

   // Register indexes
   localparam logic [2:0] CSR_CHANNEL_COUNT    = 3'd0;
   localparam logic [2:0] CSR_SAMPLE_FORMAT    = 3'd1;
   localparam logic [2:0] CSR_FADE_STEP        = 3'd2;
   localparam logic [2:0] CSR_ZERO_HOLD_ENABLE = 3'd3;
   localparam logic [2:0] CSR_ZERO_HOLD_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_DEVICE_OPEN      = 3'd5;

   // Register reset values
   localparam logic [1:0]  RST_CHANNEL_COUNT    = 2'd2;
   localparam logic [1:0]  RST_SAMPLE_FORMAT    = FMT_S16;
   localparam logic [14:0] RST_FADE_STEP        = 15'd2;
   localparam logic        RST_ZERO_HOLD_ENABLE = 1'b0;
   localparam logic [15:0] RST_ZERO_HOLD_LIMIT  = 16'd4410;
   localparam logic        RST_DEVICE_OPEN      = 1'b1;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] left_sample;
      logic signed [15:0] right_sample;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic               block_end_out;
      logic               stop_flag;
      logic               playing_now;
      logic               paused_now;
      logic               fade_done;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  channel_count;
      logic [1:0]  sample_format;
      logic [14:0] fade_step;
      logic        zero_hold_enable;
      logic [15:0] zero_hold_limit;
      logic        device_open;
   } cfg_type;

endpackage

[hw/rtl/afs_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_scale
// One channel: unpack the sample format, apply the ramp gain, repack.
// ----------------------------------------------------------------------------
module afs_scale #(
   parameter int GAIN_FRACTION_BITS = afs_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic signed [15:0]           sample_in,
   input  logic [1:0]                   sample_format,
   input  logic                         gain_active,
   input  logic [GAIN_FRACTION_BITS:0]  gain,
   output logic signed [15:0]           sample_out
);
   import afs_pkg::*;

   localparam int PW = GAIN_FRACTION_BITS + 18;

   logic signed [15:0]                    s_val;
   logic signed [GAIN_FRACTION_BITS+17:0] prod;
   logic signed [GAIN_FRACTION_BITS+17:0] shifted;
   logic [15:0]                           scaled;
   logic [15:0]                           plain;

   always_comb begin
      case (sample_format)
         FMT_S8:  s_val = {{8{sample_in[7]}}, sample_in[7:0]};
         FMT_U8:  s_val = {8'h00, sample_in[7:0]} - 16'h0080;
         default: s_val = sample_in;
      endcase
   end

   // Floor scaling: arithmetic shift of the full product
   assign prod    = PW'(s_val) * PW'($signed({1'b0, gain}));
   assign shifted = prod >>> GAIN_FRACTION_BITS;

   always_comb begin
      case (sample_format)
         FMT_S16: begin
            scaled = shifted[15:0];
            plain  = sample_in;
         end
         FMT_S8: begin
            scaled = shifted[15:0];
            plain  = {{8{sample_in[7]}}, sample_in[7:0]};
         end
         FMT_U8: begin
            scaled = {8'h00, shifted[7:0] + U8_BIAS};
            plain  = {8'h00, sample_in[7:0]};
         end
         default: begin
            scaled = sample_in;
            plain  = sample_in;
         end
      endcase
   end

   assign sample_out = gain_active ? scaled : plain;

endmodule

[hw/rtl/afs_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afs_core
// Playback state, gain ramp and result word for one request per step.
// ----------------------------------------------------------------------------
module afs_core #(
   parameter int GAIN_FRACTION_BITS = afs_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  afs_pkg::req_type req,
   input  afs_pkg::cfg_type cfg,
   output afs_pkg::rsp_type rsp
);
   import afs_pkg::*;

   localparam int GW = GAIN_FRACTION_BITS + 1;
   localparam logic [GW-1:0] UNITY = {1'b1, {GAIN_FRACTION_BITS{1'b0}}};

   logic [GW-1:0] gain_ff, gain_in;
   logic          gain_active_ff, gain_active_in;
   logic          stop_ff, stop_in;
   logic          playing_ff, playing_in;
   logic          pausing_ff, pausing_in;
   logic          paused_ff, paused_in;
   logic [15:0]   zero_count_ff, zero_count_in;

   logic signed [15:0] left_res, right_res;
   logic               two_ch;
   logic [14:0]        step_eff;
   logic [15:0]        gain_wide;
   logic [15:0]        gain_diff;
   logic               fmt_scaled;

   afs_scale #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_scale_left (
      .sample_in     (req.left_sample),
      .sample_format (cfg.sample_format),
      .gain_active   (gain_active_ff),
      .gain          (gain_ff),
      .sample_out    (left_res)
   );

   afs_scale #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_scale_right (
      .sample_in     (req.right_sample),
      .sample_format (cfg.sample_format),
      .gain_active   (gain_active_ff),
      .gain          (gain_ff),
      .sample_out    (right_res)
   );

   assign two_ch     = (MAX_CHANNELS >= 2) && (cfg.channel_count >= 2'd2);
   assign step_eff   = (cfg.fade_step == '0) ? 15'd1 : cfg.fade_step;
   assign gain_wide  = 16'(gain_ff);
   assign gain_diff  = gain_wide - {1'b0, step_eff};
   assign fmt_scaled = (cfg.sample_format != FMT_RAW);

   always_comb begin
      gain_in        = gain_ff;
      gain_active_in = gain_active_ff;
      stop_in        = stop_ff;
      playing_in     = playing_ff;
      pausing_in     = pausing_ff;
      paused_in      = paused_ff;
      zero_count_in  = zero_count_ff;

      rsp = '0;

      unique case (req.op)
         OP_FRAME: begin
            rsp.block_end_out = req.block_end;
            rsp.left_out      = left_res;
            rsp.right_out     = two_ch ? right_res : 16'sd0;
            if (fmt_scaled && gain_active_ff) begin
               if (gain_ff != '0) begin
                  // Clamp the ramp at zero
                  if ({1'b0, step_eff} >= gain_wide) begin
                     gain_in = '0;
                     if (!cfg.zero_hold_enable) begin
                        stop_in = 1'b1;
                     end
                  end else begin
                     gain_in = gain_diff[GW-1:0];
                  end
               end else if (cfg.zero_hold_enable) begin
                  if (cfg.zero_hold_limit < zero_count_ff) begin
                     stop_in = 1'b1;
                  end
                  if (zero_count_ff != '1) begin
                     zero_count_in = zero_count_ff + 16'd1;
                  end
               end
            end
         end
         OP_STOP: begin
            if (paused_ff) begin
               paused_in = 1'b0;
               if (cfg.device_open) begin
                  if (pausing_ff) begin
                     pausing_in = 1'b0;
                     paused_in  = 1'b1;
                  end
                  playing_in     = 1'b0;
                  stop_in        = 1'b0;
                  gain_active_in = 1'b0;
                  zero_count_in  = '0;
               end
            end else if (!cfg.device_open || !playing_ff) begin
               rsp.status = 1'b1;
            end else begin
               gain_active_in = 1'b1;
               gain_in        = UNITY;
            end
         end
         OP_PAUSE: begin
            if (!cfg.device_open || !playing_ff) begin
               rsp.status = 1'b1;
            end else begin
               pausing_in     = 1'b1;
               gain_active_in = 1'b1;
               gain_in        = UNITY;
            end
         end
         OP_ACK: begin
            if (!cfg.device_open) begin
               rsp.status = 1'b1;
            end else begin
               if (pausing_ff) begin
                  pausing_in = 1'b0;
                  paused_in  = 1'b1;
               end
               playing_in     = 1'b0;
               stop_in        = 1'b0;
               gain_active_in = 1'b0;
               zero_count_in  = '0;
            end
         end
         OP_START: begin
            if (!cfg.device_open) begin
               rsp.status = 1'b1;
            end else begin
               stop_in        = 1'b0;
               gain_active_in = 1'b0;
               zero_count_in  = '0;
               playing_in     = 1'b1;
            end
         end
         default: begin
            rsp.status = 1'b1;
         end
      endcase

      rsp.stop_flag   = stop_in;
      rsp.playing_now = playing_in;
      rsp.paused_now  = paused_in;
      rsp.fade_done   = !gain_active_in || (gain_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_active_ff <= 1'b0;
         stop_ff        <= 1'b0;
         playing_ff     <= 1'b0;
         pausing_ff     <= 1'b0;
         paused_ff      <= 1'b0;
         zero_count_ff  <= '0;
      end else if (step) begin
         gain_active_ff <= gain_active_in;
         stop_ff        <= stop_in;
         playing_ff     <= playing_in;
         pausing_ff     <= pausing_in;
         paused_ff      <= paused_in;
         zero_count_ff  <= zero_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         gain_ff <= gain_in;
      end
   end

   a_gain_bounded: assert property (@(posedge clock) disable iff (reset)
      gain_active_ff |-> (gain_ff <= UNITY))
      else $error("ramp gain above unity");

   a_start_rearms: assert property (@(posedge clock) disable iff (reset)
      step && (req.op == OP_START) && cfg.device_open
      |=> playing_ff && !stop_ff && !gain_active_ff && (zero_count_ff == '0))
      else $error("start did not re-arm playback");

endmodule

[hw/rtl/audio_fadeout_stop_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_fadeout_stop_controller
// Audio output stage with a linear fade-out gain ramp and stop/pause control.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_stall is low, either a frame of one or two
// samples or a control command, and returns exactly one result word for each.
// An accepted word waits in the request register while rsp_stall blocks the
// result register, then moves into it. Throughput is one word per cycle when
// not stalled, set by a single pass through the per-channel gain multiplier and
// the ramp subtract. The user must write registers through the csr port only
// while the block is idle; the block itself does not enforce this. csr_ready is
// always high and writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module audio_fadeout_stop_controller #(
   parameter int GAIN_FRACTION_BITS = afs_pkg::GAIN_FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  afs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output afs_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import afs_pkg::*;

   cfg_type cfg_ff, cfg_in;
   req_type req_ff;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_ff, rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    advance;
   logic    take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign take      = req_valid && !req_stall;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT:    cfg_in.channel_count    = csr_wdata[1:0];
            CSR_SAMPLE_FORMAT:    cfg_in.sample_format    = csr_wdata[1:0];
            CSR_FADE_STEP:        cfg_in.fade_step        = csr_wdata[14:0];
            CSR_ZERO_HOLD_ENABLE: cfg_in.zero_hold_enable = csr_wdata[0];
            CSR_ZERO_HOLD_LIMIT:  cfg_in.zero_hold_limit  = csr_wdata;
            CSR_DEVICE_OPEN:      cfg_in.device_open      = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count    <= RST_CHANNEL_COUNT;
         cfg_ff.sample_format    <= RST_SAMPLE_FORMAT;
         cfg_ff.fade_step        <= RST_FADE_STEP;
         cfg_ff.zero_hold_enable <= RST_ZERO_HOLD_ENABLE;
         cfg_ff.zero_hold_limit  <= RST_ZERO_HOLD_LIMIT;
         cfg_ff.device_open      <= RST_DEVICE_OPEN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   afs_core #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   // Request register: hold while the result side is blocked
   assign req_valid_in = take || (req_valid_ff && !advance);

   // Result register: load on advance, drop once taken
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && out_free |=> rsp_valid_ff)
      else $error("processed word missing from result register");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff && rsp_valid_ff && !rsp_stall |=> !rsp_valid_ff)
      else $error("result word appeared without a request");

endmodule
